>>> hw/rtl/attitude_error_quaternion_core_macros.svh
// Assertion macros for the attitude error quaternion core.
// Used by the RTL files that assert; expects clk and arst_n in scope.
`ifndef ATTITUDE_ERROR_QUATERNION_CORE_MACROS_SVH
`define ATTITUDE_ERROR_QUATERNION_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define AEQ_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define AEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define AEQ_ASSERT_IMPL(lbl, ante, cons, msg)
`define AEQ_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

>>> hw/rtl/aeq_pkg.sv
// Shared types, constants and the rounding multiply of the attitude error core.
// No dependencies.
package aeq_pkg;

	localparam int ANGLE_WIDTH_DEF = 16;
	localparam int QUAT_WIDTH_DEF = 16;
	localparam int CORDIC_STEPS_DEF = 16;

	localparam int WF = 30;
	localparam int LANES = 6;
	localparam int HW = 36;
	localparam int ZW = 33;
	localparam int XW = 32;
	localparam int W = 34;
	localparam int ATAN_COUNT = 31;

	typedef logic signed [HW-1:0] half_t;
	typedef logic signed [ZW-1:0] zang_t;
	typedef logic signed [XW-1:0] cs_t;
	typedef logic signed [W-1:0] fx_t;

	typedef struct packed {
		logic en;
		logic vld;
	} pipe_ctl_t;

	localparam half_t PI_W = 36'sd3373259426;
	localparam half_t HALF_PI_W = 36'sd1686629713;
	localparam half_t TWO_PI_W = 36'sd6746518852;
	localparam cs_t CORDIC_GAIN = 32'sh26DD3B6A;

	localparam logic [31:0] ATAN_TAB [ATAN_COUNT] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
		32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
		32'h00000001
	};

	// Product of two values with 30 fraction bits, rounded half up.
	function automatic fx_t mulw(fx_t a, fx_t b);
		logic signed [2*W-1:0] p;
		p = a * b;
		p = p + ((2*W)'(1) <<< (WF - 1));
		return fx_t'(p >>> WF);
	endfunction

endpackage

>>> hw/rtl/attitude_error_quaternion_core.sv
// Attitude error quaternion core: a fully pipelined datapath that takes one word of
// current and desired roll, pitch and yaw every clock cycle unless sample_stall is
// high, and returns one result word with the error quaternion, the body-frame
// error vector and its squared norm. The CORDIC pipeline runs one iteration per stage.
// A stall on the result side while a result word is valid freezes the whole pipeline.
// Depends on aeq_pkg, aeq_cordic and the assertion macro header.
`include "attitude_error_quaternion_core_macros.svh"
module attitude_error_quaternion_core import aeq_pkg::*; #(
	parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
	parameter int QUAT_WIDTH = QUAT_WIDTH_DEF,
	parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	output logic sample_stall,
	input logic signed [ANGLE_WIDTH-1:0] roll_now,
	input logic signed [ANGLE_WIDTH-1:0] pitch_now,
	input logic signed [ANGLE_WIDTH-1:0] yaw_now,
	input logic signed [ANGLE_WIDTH-1:0] roll_target,
	input logic signed [ANGLE_WIDTH-1:0] pitch_target,
	input logic signed [ANGLE_WIDTH-1:0] yaw_target,
	output logic result_valid,
	input logic result_stall,
	output logic signed [QUAT_WIDTH-1:0] err_w,
	output logic signed [QUAT_WIDTH-1:0] err_x,
	output logic signed [QUAT_WIDTH-1:0] err_y,
	output logic signed [QUAT_WIDTH-1:0] err_z,
	output logic signed [QUAT_WIDTH-1:0] body_err_x,
	output logic signed [QUAT_WIDTH-1:0] body_err_y,
	output logic signed [QUAT_WIDTH-1:0] body_err_z,
	output logic [QUAT_WIDTH-2:0] err_vec_sq
);

	localparam int AF = ANGLE_WIDTH - 4;
	localparam int SHN = WF - AF;
	localparam int SHT = WF - 1 - AF;
	localparam int OS = WF - (QUAT_WIDTH - 2);
	localparam fx_t ORND = fx_t'((64'd1 << OS) >> 1);
	localparam fx_t OHI = fx_t'((64'sd1 <<< (QUAT_WIDTH - 1)) - 64'sd1);
	localparam fx_t OLO = -OHI - fx_t'(1);
	localparam zang_t ZHALF = zang_t'(HALF_PI_W);

	logic en;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic vld_s7, vld_s8, vld_s9, vld_s10, vld_s11, vld_s12;
	logic vld_c;

	half_t h_d [LANES];
	half_t h_s1 [LANES];
	zang_t z_s2 [LANES];
	logic [LANES-1:0] neg_s2;
	cs_t cx [LANES];
	cs_t sy [LANES];
	logic [LANES-1:0] nc;
	fx_t c_s3 [LANES];
	fx_t s_s3 [LANES];
	fx_t cc_s4 [2], ss_s4 [2], sc_s4 [2], cs_s4 [2], cy_s4 [2], sy_s4 [2];
	fx_t p_s5 [2][8];
	fx_t q_s6 [2][4];
	fx_t ep_s7 [16];
	fx_t dq_s7 [10];
	fx_t e_s8 [4];
	fx_t d_s8 [9];
	fx_t e_s9 [4];
	fx_t d_s9 [9];
	fx_t bp_s10 [9];
	fx_t sp_s10 [3];
	fx_t e_s10 [4];
	fx_t b_s11 [3];
	fx_t sq_s11;
	fx_t e_s11 [4];
	logic signed [QUAT_WIDTH-1:0] o_s12 [7];
	logic [QUAT_WIDTH-2:0] sq_s12;

	function automatic logic signed [QUAT_WIDTH-1:0] out_sat(fx_t v);
		fx_t r;
		r = (v + ORND) >>> OS;
		if (r > OHI) begin
			r = OHI;
		end else if (r < OLO) begin
			r = OLO;
		end
		return r[QUAT_WIDTH-1:0];
	endfunction

	function automatic logic [QUAT_WIDTH-2:0] sq_sat(fx_t v);
		fx_t r;
		r = (v + ORND) >>> OS;
		if (r > OHI) begin
			r = OHI;
		end else if (r < 0) begin
			r = '0;
		end
		return r[QUAT_WIDTH-2:0];
	endfunction

	assign en = !(vld_s12 && result_stall);
	assign sample_stall = vld_s12 && result_stall;
	assign result_valid = vld_s12;

	always_comb begin
		logic signed [ANGLE_WIDTH-1:0] an [3];
		logic signed [ANGLE_WIDTH-1:0] at [3];
		half_t a;
		half_t t;
		an = '{roll_now, pitch_now, yaw_now};
		at = '{roll_target, pitch_target, yaw_target};
		for (int k = 0; k < 3; k++) begin
			a = half_t'(an[k]) <<< SHN;
			t = a + PI_W;
			if (t < 0) begin
				t = t + TWO_PI_W;
			end else if (t >= TWO_PI_W) begin
				t = t - TWO_PI_W;
			end
			h_d[k] = (t - PI_W) >>> 1;
			h_d[k+3] = half_t'(at[k]) <<< SHT;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
			vld_s12 <= 1'b0;
		end else if (en) begin
			vld_s1 <= sample_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_c;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= vld_s6;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
			vld_s12 <= vld_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_s1 <= h_d;
			for (int k = 0; k < LANES; k++) begin
				if (h_s1[k] > HALF_PI_W) begin
					z_s2[k] <= zang_t'(h_s1[k] - PI_W);
					neg_s2[k] <= 1'b1;
				end else if (h_s1[k] < -HALF_PI_W) begin
					z_s2[k] <= zang_t'(h_s1[k] + PI_W);
					neg_s2[k] <= 1'b1;
				end else begin
					z_s2[k] <= zang_t'(h_s1[k]);
					neg_s2[k] <= 1'b0;
				end
			end
		end
	end

	aeq_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.ctl('{en: en, vld: vld_s2}),
		.z(z_s2),
		.neg(neg_s2),
		.cos_o(cx),
		.sin_o(sy),
		.neg_o(nc),
		.vld_o(vld_c)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < LANES; k++) begin
				c_s3[k] <= nc[k] ? -fx_t'(cx[k]) : fx_t'(cx[k]);
				s_s3[k] <= nc[k] ? -fx_t'(sy[k]) : fx_t'(sy[k]);
			end
			for (int b = 0; b < 2; b++) begin
				cc_s4[b] <= mulw(c_s3[3*b], c_s3[3*b+1]);
				ss_s4[b] <= mulw(s_s3[3*b], s_s3[3*b+1]);
				sc_s4[b] <= mulw(s_s3[3*b], c_s3[3*b+1]);
				cs_s4[b] <= mulw(c_s3[3*b], s_s3[3*b+1]);
				cy_s4[b] <= c_s3[3*b+2];
				sy_s4[b] <= s_s3[3*b+2];
				p_s5[b][0] <= mulw(cc_s4[b], cy_s4[b]);
				p_s5[b][1] <= mulw(ss_s4[b], sy_s4[b]);
				p_s5[b][2] <= mulw(sc_s4[b], cy_s4[b]);
				p_s5[b][3] <= mulw(cs_s4[b], sy_s4[b]);
				p_s5[b][4] <= mulw(cs_s4[b], cy_s4[b]);
				p_s5[b][5] <= mulw(sc_s4[b], sy_s4[b]);
				p_s5[b][6] <= mulw(cc_s4[b], sy_s4[b]);
				p_s5[b][7] <= mulw(ss_s4[b], cy_s4[b]);
				q_s6[b][0] <= p_s5[b][0] + p_s5[b][1];
				q_s6[b][1] <= p_s5[b][2] - p_s5[b][3];
				q_s6[b][2] <= p_s5[b][4] + p_s5[b][5];
				q_s6[b][3] <= p_s5[b][6] - p_s5[b][7];
			end
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 4; j++) begin
					ep_s7[4*i+j] <= mulw(q_s6[1][i], q_s6[0][j]);
				end
			end
			dq_s7[0] <= mulw(q_s6[0][0], q_s6[0][0]);
			dq_s7[1] <= mulw(q_s6[0][1], q_s6[0][1]);
			dq_s7[2] <= mulw(q_s6[0][2], q_s6[0][2]);
			dq_s7[3] <= mulw(q_s6[0][3], q_s6[0][3]);
			dq_s7[4] <= mulw(q_s6[0][1], q_s6[0][2]);
			dq_s7[5] <= mulw(q_s6[0][0], q_s6[0][3]);
			dq_s7[6] <= mulw(q_s6[0][0], q_s6[0][2]);
			dq_s7[7] <= mulw(q_s6[0][1], q_s6[0][3]);
			dq_s7[8] <= mulw(q_s6[0][2], q_s6[0][3]);
			dq_s7[9] <= mulw(q_s6[0][0], q_s6[0][1]);

			e_s8[0] <= ep_s7[0] + ep_s7[5] + ep_s7[10] + ep_s7[15];
			e_s8[1] <= -ep_s7[1] + ep_s7[4] - ep_s7[11] + ep_s7[14];
			e_s8[2] <= -ep_s7[2] + ep_s7[7] + ep_s7[8] - ep_s7[13];
			e_s8[3] <= -ep_s7[3] - ep_s7[6] + ep_s7[9] + ep_s7[12];
			d_s8[0] <= dq_s7[0] + dq_s7[1] - dq_s7[2] - dq_s7[3];
			d_s8[4] <= dq_s7[0] - dq_s7[1] + dq_s7[2] - dq_s7[3];
			d_s8[8] <= dq_s7[0] - dq_s7[1] - dq_s7[2] + dq_s7[3];
			d_s8[1] <= (dq_s7[4] - dq_s7[5]) <<< 1;
			d_s8[2] <= (dq_s7[6] + dq_s7[7]) <<< 1;
			d_s8[3] <= (dq_s7[4] + dq_s7[5]) <<< 1;
			d_s8[5] <= (dq_s7[8] - dq_s7[9]) <<< 1;
			d_s8[6] <= (dq_s7[7] - dq_s7[6]) <<< 1;
			d_s8[7] <= (dq_s7[8] + dq_s7[9]) <<< 1;

			e_s9[0] <= e_s8[0];
			for (int i = 1; i < 4; i++) begin
				e_s9[i] <= e_s8[0][W-1] ? -e_s8[i] : e_s8[i];
			end
			d_s9 <= d_s8;

			for (int i = 0; i < 3; i++) begin
				for (int r = 0; r < 3; r++) begin
					bp_s10[3*i+r] <= mulw(d_s9[3*r+i], e_s9[r+1]);
				end
				sp_s10[i] <= mulw(e_s9[i+1], e_s9[i+1]);
			end
			e_s10 <= e_s9;

			for (int i = 0; i < 3; i++) begin
				b_s11[i] <= bp_s10[3*i] + bp_s10[3*i+1] + bp_s10[3*i+2];
			end
			sq_s11 <= sp_s10[0] + sp_s10[1] + sp_s10[2];
			e_s11 <= e_s10;

			for (int i = 0; i < 4; i++) begin
				o_s12[i] <= out_sat(e_s11[i]);
			end
			for (int i = 0; i < 3; i++) begin
				o_s12[4+i] <= out_sat(b_s11[i]);
			end
			sq_s12 <= sq_sat(sq_s11);
		end
	end

	assign err_w = o_s12[0];
	assign err_x = o_s12[1];
	assign err_y = o_s12[2];
	assign err_z = o_s12[3];
	assign body_err_x = o_s12[4];
	assign body_err_y = o_s12[5];
	assign body_err_z = o_s12[6];
	assign err_vec_sq = sq_s12;

	`AEQ_ASSERT_IMPL(a_wrap_range, vld_s1, (h_s1[0] >= -HALF_PI_W) && (h_s1[0] < HALF_PI_W), "wrapped half angle out of range")
	`AEQ_ASSERT_IMPL(a_reduced_range, vld_s2, (z_s2[5] <= ZHALF) && (z_s2[5] >= -ZHALF), "reduced angle beyond a quarter turn")
	`AEQ_ASSERT_NEXT(a_sign_rule, en && vld_s8 && e_s8[0][W-1], e_s9[1] == -$past(e_s8[1]), "vector part not negated")
	`AEQ_ASSERT_IMPL(a_sq_nonneg, vld_s11, !sq_s11[W-1], "negative squared norm")
	`AEQ_ASSERT_NEXT(a_stall_holds, !en, $stable(vld_s1) && $stable(vld_s6), "pipeline moved while stalled")

endmodule

>>> hw/rtl/aeq_cordic.sv
// Six-lane pipelined rotation CORDIC, one iteration per register stage.
// Depends on aeq_pkg.
module aeq_cordic import aeq_pkg::*; #(
	parameter int STEPS = CORDIC_STEPS_DEF
) (
	input logic clk,
	input logic arst_n,
	input pipe_ctl_t ctl,
	input zang_t z [LANES],
	input logic [LANES-1:0] neg,
	output cs_t cos_o [LANES],
	output cs_t sin_o [LANES],
	output logic [LANES-1:0] neg_o,
	output logic vld_o
);

	cs_t xs [1:STEPS][LANES];
	cs_t ys [1:STEPS][LANES];
	zang_t zs [1:STEPS][LANES];
	logic [LANES-1:0] ns [1:STEPS];
	logic vs [1:STEPS];

	for (genvar g = 0; g < STEPS; g++) begin : g_step
		cs_t xp [LANES];
		cs_t yp [LANES];
		zang_t zp [LANES];
		logic [LANES-1:0] np;
		logic vp;

		if (g == 0) begin : g_src
			always_comb begin
				for (int k = 0; k < LANES; k++) begin
					xp[k] = CORDIC_GAIN;
					yp[k] = '0;
					zp[k] = z[k];
				end
				np = neg;
				vp = ctl.vld;
			end
		end else begin : g_src
			assign xp = xs[g];
			assign yp = ys[g];
			assign zp = zs[g];
			assign np = ns[g];
			assign vp = vs[g];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vs[g+1] <= 1'b0;
			end else if (ctl.en) begin
				vs[g+1] <= vp;
			end
		end

		always_ff @(posedge clk) begin
			if (ctl.en) begin
				ns[g+1] <= np;
				for (int k = 0; k < LANES; k++) begin
					if (!zp[k][ZW-1]) begin
						xs[g+1][k] <= xp[k] - (yp[k] >>> g);
						ys[g+1][k] <= yp[k] + (xp[k] >>> g);
						zs[g+1][k] <= zp[k] - zang_t'({1'b0, ATAN_TAB[g]});
					end else begin
						xs[g+1][k] <= xp[k] + (yp[k] >>> g);
						ys[g+1][k] <= yp[k] - (xp[k] >>> g);
						zs[g+1][k] <= zp[k] + zang_t'({1'b0, ATAN_TAB[g]});
					end
				end
			end
		end
	end

	assign cos_o = xs[STEPS];
	assign sin_o = ys[STEPS];
	assign neg_o = ns[STEPS];
	assign vld_o = vs[STEPS];

endmodule

>>> tb/tb_attitude_error_quaternion_core.sv
// Self-checking testbench for attitude_error_quaternion_core.
// Each accepted angle word is run through a bit-exact predictor, and every result word
// is checked in order. Needs the core, aeq_cordic, the macro header and their package.
`timescale 1ns / 100ps
module tb_attitude_error_quaternion_core;

	typedef logic signed [15:0] angle_t;
	typedef struct packed {
		angle_t roll_now, pitch_now, yaw_now, roll_target, pitch_target, yaw_target;
	} angle_word_t;
	typedef struct packed {
		logic signed [15:0] w, x, y, z, bx, by, bz;
		logic [14:0] sq;
	} err_word_t;

	localparam longint PI_Q30 = 64'sd3373259426;
	localparam longint HALF_PI_Q30 = 64'sd1686629713;
	localparam longint GAIN_Q30 = 64'sh26DD3B6A;
	localparam int NUM_RANDOM = 700;
	localparam int NUM_DIRECTED = 14;
	localparam int WATCHDOG_LIMIT = 3000;

	localparam longint ATAN_Q30 [16] = '{
		64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
		64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
		64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
		64'h00007FFF
	};

	// Directed words: zero, extremes, pi and wrap edges, large half angles,
	// and attitude pairs that give a negative or zero error scalar.
	localparam angle_word_t DIRECTED [NUM_DIRECTED] = '{
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767},
		'{-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768},
		'{16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768},
		'{16'sd12868, 16'sd12868, 16'sd12868, 16'sd0, 16'sd0, 16'sd0},
		'{-16'sd12868, -16'sd12868, -16'sd12868, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd12867, -16'sd12867, 16'sd12869, -16'sd12869, 16'sd6434, -16'sd6434},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd25736},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd25000, 16'sd0, 16'sd0},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd0, -16'sd20000, 16'sd0},
		'{16'sd25736, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0},
		'{16'sd1000, 16'sd2000, 16'sd3000, 16'sd1000, 16'sd2000, 16'sd3000},
		'{16'sd0, 16'sd0, 16'sd0, 16'sd12868, 16'sd0, 16'sd0},
		'{16'sd4096, -16'sd4096, 16'sd8192, 16'sd30000, -16'sd30000, 16'sd15000}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	angle_t roll_now = '0, pitch_now = '0, yaw_now = '0;
	angle_t roll_target = '0, pitch_target = '0, yaw_target = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [15:0] err_w, err_x, err_y, err_z, body_err_x, body_err_y, body_err_z;
	logic [14:0] err_vec_sq;

	err_word_t pending_errors [$];
	int words_sent = 0;
	int mismatches = 0;
	int idle_cycles = 0;
	bit hold_done = 1'b0;

	attitude_error_quaternion_core dut (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic longint fsar(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint fround(longint v, int s);
		return (v + (64'sd1 <<< (s - 1))) >>> s;
	endfunction

	function automatic longint fmul(longint a, longint b);
		return fround(a * b, 30);
	endfunction

	function automatic void cordic_sin_cos(input longint h, output longint c, output longint s);
		bit flip;
		longint x, y, z, t;
		flip = 1'b0;
		x = GAIN_Q30;
		y = 0;
		if (h > HALF_PI_Q30) begin
			h -= PI_Q30;
			flip = 1'b1;
		end else if (h < -HALF_PI_Q30) begin
			h += PI_Q30;
			flip = 1'b1;
		end
		z = h;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				t = x - fsar(y, i);
				y = y + fsar(x, i);
				z -= ATAN_Q30[i];
			end else begin
				t = x + fsar(y, i);
				y = y - fsar(x, i);
				z += ATAN_Q30[i];
			end
			x = t;
		end
		c = flip ? -x : x;
		s = flip ? -y : y;
	endfunction

	function automatic void euler_to_quat(input longint h [3], output longint q [4]);
		longint cr, sr, cp, sp, cy, sy;
		cordic_sin_cos(h[0], cr, sr);
		cordic_sin_cos(h[1], cp, sp);
		cordic_sin_cos(h[2], cy, sy);
		q[0] = fmul(fmul(cr, cp), cy) + fmul(fmul(sr, sp), sy);
		q[1] = fmul(fmul(sr, cp), cy) - fmul(fmul(cr, sp), sy);
		q[2] = fmul(fmul(cr, sp), cy) + fmul(fmul(sr, cp), sy);
		q[3] = fmul(fmul(cr, cp), sy) - fmul(fmul(sr, sp), cy);
	endfunction

	function automatic logic signed [15:0] to_q14(longint v);
		longint r;
		r = fround(v, 16);
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r[15:0];
	endfunction

	function automatic err_word_t predict_attitude_error(angle_word_t a);
		longint raw_now [3], raw_target [3], hn [3], ht [3], qn [4], qt [4], e [4];
		longint d [3][3], body [3], w2, x2, y2, z2, sq, r;
		err_word_t res;
		raw_now = '{longint'(a.roll_now), longint'(a.pitch_now), longint'(a.yaw_now)};
		raw_target = '{longint'(a.roll_target), longint'(a.pitch_target),
			longint'(a.yaw_target)};
		for (int i = 0; i < 3; i++) begin
			r = (raw_now[i] * (64'sd1 <<< 18) + PI_Q30) % (2 * PI_Q30);
			if (r < 0)
				r += 2 * PI_Q30;
			hn[i] = (r - PI_Q30) >>> 1;
			ht[i] = raw_target[i] * (64'sd1 <<< 17);
		end
		euler_to_quat(hn, qn);
		euler_to_quat(ht, qt);
		e[0] = fmul(qt[0], qn[0]) + fmul(qt[1], qn[1]) + fmul(qt[2], qn[2])
			+ fmul(qt[3], qn[3]);
		e[1] = -fmul(qt[0], qn[1]) + fmul(qt[1], qn[0]) - fmul(qt[2], qn[3])
			+ fmul(qt[3], qn[2]);
		e[2] = -fmul(qt[0], qn[2]) + fmul(qt[1], qn[3]) + fmul(qt[2], qn[0])
			- fmul(qt[3], qn[1]);
		e[3] = -fmul(qt[0], qn[3]) - fmul(qt[1], qn[2]) + fmul(qt[2], qn[1])
			+ fmul(qt[3], qn[0]);
		if (e[0] < 0)
			for (int i = 1; i < 4; i++)
				e[i] = -e[i];
		w2 = fmul(qn[0], qn[0]);
		x2 = fmul(qn[1], qn[1]);
		y2 = fmul(qn[2], qn[2]);
		z2 = fmul(qn[3], qn[3]);
		d[0][0] = w2 + x2 - y2 - z2;
		d[1][1] = w2 - x2 + y2 - z2;
		d[2][2] = w2 - x2 - y2 + z2;
		d[0][1] = 2 * (fmul(qn[1], qn[2]) - fmul(qn[0], qn[3]));
		d[0][2] = 2 * (fmul(qn[0], qn[2]) + fmul(qn[1], qn[3]));
		d[1][0] = 2 * (fmul(qn[1], qn[2]) + fmul(qn[0], qn[3]));
		d[1][2] = 2 * (fmul(qn[2], qn[3]) - fmul(qn[0], qn[1]));
		d[2][0] = 2 * (fmul(qn[1], qn[3]) - fmul(qn[0], qn[2]));
		d[2][1] = 2 * (fmul(qn[2], qn[3]) + fmul(qn[0], qn[1]));
		for (int i = 0; i < 3; i++)
			body[i] = fmul(d[0][i], e[1]) + fmul(d[1][i], e[2]) + fmul(d[2][i], e[3]);
		sq = fround(fmul(e[1], e[1]) + fmul(e[2], e[2]) + fmul(e[3], e[3]), 16);
		if (sq > 32767)
			sq = 32767;
		if (sq < 0)
			sq = 0;
		res.w = to_q14(e[0]);
		res.x = to_q14(e[1]);
		res.y = to_q14(e[2]);
		res.z = to_q14(e[3]);
		res.bx = to_q14(body[0]);
		res.by = to_q14(body[1]);
		res.bz = to_q14(body[2]);
		res.sq = sq[14:0];
		return res;
	endfunction

	function automatic angle_t random_angle();
		if ($urandom_range(0, 2) == 0)
			return angle_t'($urandom());
		return angle_t'($signed($urandom_range(0, 25736)) - 12868);
	endfunction

	function automatic angle_word_t next_word(int n);
		angle_word_t a;
		if (n < NUM_DIRECTED)
			return DIRECTED[n];
		a.roll_now = random_angle();
		a.pitch_now = random_angle();
		a.yaw_now = random_angle();
		a.roll_target = random_angle();
		a.pitch_target = random_angle();
		a.yaw_target = random_angle();
		return a;
	endfunction

	// Phases of the run: no idling, sender idle, receiver stalling, both.
	function automatic int idle_percent(bit receiver);
		int phase;
		phase = (words_sent * 4) / (NUM_DIRECTED + NUM_RANDOM);
		case (phase)
			1: return receiver ? 0 : 58;
			2: return receiver ? 58 : 0;
			3: return 26;
			default: return 0;
		endcase
	endfunction

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
	end

	initial begin
		angle_word_t cur;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (sample_valid && !sample_stall) begin
				pending_errors.push_back(predict_attitude_error(cur));
				words_sent++;
			end
			if (!sample_valid || !sample_stall) begin
				if (words_sent < NUM_DIRECTED + NUM_RANDOM
					&& $urandom_range(1, 100) > idle_percent(1'b0)) begin
					cur = next_word(words_sent);
					sample_valid <= 1'b1;
					{roll_now, pitch_now, yaw_now, roll_target, pitch_target, yaw_target}
						<= cur;
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// The receiver also holds off once for a long stretch so the pipeline fills.
	initial begin
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!hold_done && words_sent >= 60) begin
				hold_done = 1'b1;
				result_stall <= 1'b1;
				repeat (200) @(posedge clk);
			end
			result_stall <= ($urandom_range(1, 100) <= idle_percent(1'b1));
		end
	end

	always @(posedge clk) begin
		err_word_t got, want;
		if (result_valid && !result_stall) begin
			got = '{err_w, err_x, err_y, err_z, body_err_x, body_err_y, body_err_z,
				err_vec_sq};
			if (pending_errors.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected result word: %p", got);
			end else begin
				want = pending_errors.pop_front();
				if (got.w !== want.w || got.x !== want.x || got.y !== want.y
					|| got.z !== want.z || got.bx !== want.bx || got.by !== want.by
					|| got.bz !== want.bz || got.sq !== want.sq) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_valid && !sample_stall) || (result_valid && !result_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	initial begin
		@(posedge arst_n);
		while (words_sent < NUM_DIRECTED + NUM_RANDOM || pending_errors.size() != 0) begin
			@(posedge clk);
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
		repeat (60) @(posedge clk);
		if (mismatches == 0 && pending_errors.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/aeq_pkg.sv
hw/rtl/aeq_cordic.sv
hw/rtl/attitude_error_quaternion_core.sv
tb/tb_attitude_error_quaternion_core.sv
